@@ sv/tedq_pkg.sv @@
// Shared types, constants and helper functions for the time ordered event queue.
// Used by tedq_store, tedq_seq and time_ordered_event_queue; depends on nothing.
`timescale 1ns / 1ps

package tedq_pkg;

    // Number of entries held in the store.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 32;
    localparam int OCC_W    = 5;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT,
        S_PLACE,
        S_POPRD,
        S_DONE
    } seq_state_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  proc_id;
        logic [15:0] event_time;
        logic [7:0]  state_code;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       proc_id;
        logic [7:0]       state_code;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    // Store access request for one cycle.
    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        idx_t   raddr;
    } mem_req_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic idle;
        cnt_t count;
    } seq_status_t;

    // Entry word: id in 31..24, time in 23..8, state in 7..0.
    function automatic entry_t pack_entry(input item_t it);
        return {it.proc_id, it.event_time, it.state_code};
    endfunction

    function automatic logic [15:0] entry_time(input entry_t e);
        return e[23:8];
    endfunction

    // Circular pointer steps.
    function automatic idx_t idx_next(input idx_t i);
        return (i == idx_t'(CAPACITY - 1)) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        return (i == '0) ? idx_t'(CAPACITY - 1) : idx_t'(i - idx_t'(1));
    endfunction

endpackage

@@ sv/tedq_store.sv @@
// Entry store of the event queue: one write port and one registered read port.
// Depends on tedq_pkg for the entry and request types.
`timescale 1ns / 1ps

module tedq_store
(
    input  logic              clk,
    input  tedq_pkg::mem_req_t req,
    output tedq_pkg::entry_t   rdata
);

    tedq_pkg::entry_t mem [tedq_pkg::CAPACITY];
    tedq_pkg::entry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tedq_seq.sv @@
// Sequencer of the event queue: circular pointers, count and the shared time compare.
// Depends on tedq_pkg; drives the tedq_store request and reads its registered data.
`timescale 1ns / 1ps

module tedq_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  tedq_pkg::item_t        item_in,
    input  tedq_pkg::entry_t       rdata,
    input  logic                   res_ready,
    output tedq_pkg::mem_req_t     req,
    output logic                   res_valid,
    output tedq_pkg::result_t      res,
    output tedq_pkg::seq_status_t  stat
);

    tedq_pkg::seq_state_t state_reg, state_next;
    tedq_pkg::idx_t       head_reg, head_next;
    tedq_pkg::idx_t       tail_reg, tail_next;
    tedq_pkg::idx_t       gap_reg, gap_next;
    tedq_pkg::idx_t       pos_reg, pos_next;
    tedq_pkg::cnt_t       count_reg, count_next;
    tedq_pkg::cnt_t       left_reg, left_next;
    tedq_pkg::item_t      item_reg, item_next;
    logic [1:0]           status_reg, status_next;
    logic [7:0]           rid_reg, rid_next;
    logic [7:0]           rst_reg, rst_next;
    logic                 full;
    logic                 later;

    assign full  = (count_reg == tedq_pkg::cnt_t'(tedq_pkg::CAPACITY));
    // The one compare unit: is the entry just read later than the new item?
    assign later = (tedq_pkg::entry_time(rdata) > item_reg.event_time);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tedq_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge clk)
    begin
        gap_reg    <= gap_next;
        pos_reg    <= pos_next;
        left_reg   <= left_next;
        item_reg   <= item_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rst_reg    <= rst_next;
    end

    // Next state and store requests.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        gap_next    = gap_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        item_next   = item_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        rst_next    = rst_reg;
        req.we      = 1'b0;
        req.waddr   = tail_reg;
        req.wdata   = tedq_pkg::pack_entry(item_reg);
        req.raddr   = head_reg;
        res_valid   = 1'b0;

        unique case (state_reg)
            tedq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item_in;
                    status_next = tedq_pkg::ST_DONE;
                    rid_next    = '0;
                    rst_next    = '0;
                    state_next  = tedq_pkg::S_DONE;
                    unique case (item_in.op) inside
                        tedq_pkg::OP_APPEND, tedq_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = tedq_pkg::ST_FULL;
                            end
                            else if (item_in.op == tedq_pkg::OP_APPEND || count_reg == '0)
                            begin
                                // Nothing to walk past: write straight at the back.
                                req.we     = 1'b1;
                                req.waddr  = tail_reg;
                                req.wdata  = tedq_pkg::pack_entry(item_in);
                                tail_next  = tedq_pkg::idx_next(tail_reg);
                                count_next = count_reg + tedq_pkg::cnt_t'(1);
                            end
                            else
                            begin
                                // Scan from the front for the first later record.
                                req.raddr  = head_reg;
                                pos_next   = head_reg;
                                gap_next   = tail_reg;
                                left_next  = count_reg;
                                state_next = tedq_pkg::S_CMP;
                            end
                        end
                        tedq_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = tedq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                req.raddr  = head_reg;
                                state_next = tedq_pkg::S_POPRD;
                            end
                        end
                        default:
                        begin
                            // Unused opcode: report done and change nothing.
                        end
                    endcase
                end
            end

            tedq_pkg::S_CMP:
            begin
                if (later)
                begin
                    // The new record goes here: open the gap from the back.
                    req.raddr  = tedq_pkg::idx_prev(tail_reg);
                    state_next = tedq_pkg::S_SHIFT;
                end
                else if (left_reg == tedq_pkg::cnt_t'(1))
                begin
                    // No later record is held: the new one goes at the back.
                    state_next = tedq_pkg::S_PLACE;
                end
                else
                begin
                    req.raddr = tedq_pkg::idx_next(pos_reg);
                    pos_next  = tedq_pkg::idx_next(pos_reg);
                    left_next = left_reg - tedq_pkg::cnt_t'(1);
                end
            end

            tedq_pkg::S_SHIFT:
            begin
                // Move one record up into the gap and read the one below.
                req.we    = 1'b1;
                req.waddr = gap_reg;
                req.wdata = rdata;
                req.raddr = tedq_pkg::idx_prev(tedq_pkg::idx_prev(gap_reg));
                gap_next  = tedq_pkg::idx_prev(gap_reg);
                left_next = left_reg - tedq_pkg::cnt_t'(1);
                if (left_reg == tedq_pkg::cnt_t'(1))
                begin
                    state_next = tedq_pkg::S_PLACE;
                end
            end

            tedq_pkg::S_PLACE:
            begin
                req.we     = 1'b1;
                req.waddr  = gap_reg;
                req.wdata  = tedq_pkg::pack_entry(item_reg);
                tail_next  = tedq_pkg::idx_next(tail_reg);
                count_next = count_reg + tedq_pkg::cnt_t'(1);
                state_next = tedq_pkg::S_DONE;
            end

            tedq_pkg::S_POPRD:
            begin
                rid_next   = rdata[31:24];
                rst_next   = rdata[7:0];
                head_next  = tedq_pkg::idx_next(head_reg);
                count_next = count_reg - tedq_pkg::cnt_t'(1);
                state_next = tedq_pkg::S_DONE;
            end

            tedq_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = tedq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tedq_pkg::S_IDLE;
            end
        endcase
    end

    assign res.status     = status_reg;
    assign res.proc_id    = rid_reg;
    assign res.state_code = rst_reg;
    assign res.occupancy  = tedq_pkg::OCC_W'(count_reg);

    assign stat.idle  = (state_reg == tedq_pkg::S_IDLE);
    assign stat.count = count_reg;

endmodule

@@ sv/time_ordered_event_queue.sv @@
// Bounded queue of process records (id, time, state) with append, time ordered insert and
// pop front. The records sit in a circular store with head and tail pointers. An ordered
// insert scans from the front through one shared time compare to the first record later
// than the new one, then moves the records from there to the back up one place per cycle.
// Equal times go after the records already held. One item is worked at a time; a
// finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module time_ordered_event_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  proc_id,
    input  logic [15:0] event_time,
    input  logic [7:0]  state_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  out_proc_id,
    output logic [7:0]  out_state,
    output logic [4:0]  occupancy
);

    tedq_pkg::item_t       item_in;
    tedq_pkg::mem_req_t    req;
    tedq_pkg::entry_t      rdata;
    tedq_pkg::result_t     res;
    tedq_pkg::seq_status_t stat;
    tedq_pkg::result_t     out_res_reg;
    logic                  out_valid_reg;
    logic                  start;
    logic                  res_valid;
    logic                  res_ready;

    // Input side: an item is taken whenever the sequencer is idle.
    assign in_stall = !stat.idle;
    assign start    = in_valid && !in_stall;

    assign item_in.op         = opcode;
    assign item_in.proc_id    = proc_id;
    assign item_in.event_time = event_time;
    assign item_in.state_code = state_code;

    tedq_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_in   (item_in),
        .rdata     (rdata),
        .res_ready (res_ready),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .stat      (stat)
    );

    tedq_store u_store
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // Output register: loads a result when empty or being taken.
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign out_proc_id = out_res_reg.proc_id;
    assign out_state   = out_res_reg.state_code;
    assign occupancy   = out_res_reg.occupancy;

    // The count never goes past the store size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= tedq_pkg::cnt_t'(tedq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // An accepted item keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !stat.idle)
        else $error("sequencer idle right after accepting an item");

    // A refused add only happens on a full queue.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tedq_pkg::ST_FULL)
            |-> occupancy == tedq_pkg::OCC_W'(tedq_pkg::CAPACITY))
        else $error("full status with room left");

    // An empty pop reports an empty queue and zero payload.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tedq_pkg::ST_EMPTY)
            |-> (occupancy == '0 && out_proc_id == '0 && out_state == '0))
        else $error("empty status with entries or payload");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the time ordered event queue: a predictor of the record list,
// a scoreboard class, the tasks that drive the input handshake and a block that varies the
// result stall. Depends on tedq_pkg and time_ordered_event_queue.
`timescale 1ns / 1ps

module tb_top;

    import tedq_pkg::*;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 500;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 3000;

    // One record as the predictor keeps it.
    typedef struct {
        logic [7:0]  pid;
        logic [15:0] etime;
        logic [7:0]  st;
    } record_t;

    // Keeps its own copy of the record list and the results it implies.
    class event_queue_scoreboard;
        record_t held[$];
        result_t awaited[$];
        int      failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted item to the predicted list and queue its result.
        function void note_request(item_t it);
            result_t exp;
            record_t rec;
            int      pos;
            exp = '0;
            rec = '{it.proc_id, it.event_time, it.state_code};
            case (opcode_t'(it.op))
                OP_APPEND:
                begin
                    if (held.size() >= CAPACITY)
                        exp.status = ST_FULL;
                    else
                        held.push_back(rec);
                end
                OP_INSERT:
                begin
                    if (held.size() >= CAPACITY)
                    begin
                        exp.status = ST_FULL;
                    end
                    else
                    begin
                        // Equal times go behind the records already held.
                        pos = 0;
                        while (pos < held.size() && held[pos].etime <= it.event_time)
                            pos++;
                        held.insert(pos, rec);
                    end
                end
                OP_POP:
                begin
                    if (held.size() == 0)
                    begin
                        exp.status = ST_EMPTY;
                    end
                    else
                    begin
                        rec = held.pop_front();
                        exp.proc_id    = rec.pid;
                        exp.state_code = rec.st;
                    end
                end
                default:
                begin
                end
            endcase
            exp.occupancy = OCC_W'(held.size());
            awaited.push_back(exp);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_response(result_t got);
            result_t exp;
            if (awaited.size() == 0)
            begin
                $error("result item with no expectation waiting");
                failures++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                failures++;
            end
            if (got.proc_id !== exp.proc_id)
            begin
                $error("out_proc_id: expected %0d, actual %0d", exp.proc_id, got.proc_id);
                failures++;
            end
            if (got.state_code !== exp.state_code)
            begin
                $error("out_state: expected %0d, actual %0d", exp.state_code, got.state_code);
                failures++;
            end
            if (got.occupancy !== exp.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", exp.occupancy, got.occupancy);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [7:0]  proc_id = '0;
    logic [15:0] event_time = '0;
    logic [7:0]  state_code = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [1:0]  status;
    logic [7:0]  out_proc_id;
    logic [7:0]  out_state;
    logic [4:0]  occupancy;

    event_queue_scoreboard sb;

    int  results_seen = 0;
    int  stretch_left = 0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;

    time_ordered_event_queue DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .proc_id     (proc_id),
        .event_time  (event_time),
        .state_code  (state_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_proc_id (out_proc_id),
        .out_state   (out_state),
        .occupancy   (occupancy)
    );

    always #2 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic item_t make_item(opcode_t op, logic [7:0] pid, logic [15:0] t,
                                        logic [7:0] st);
        item_t it;
        it.op         = op;
        it.proc_id    = pid;
        it.event_time = t;
        it.state_code = st;
        return it;
    endfunction

    // Random item; add_pct sets how often records are added rather than popped.
    function automatic item_t random_item(int add_pct);
        item_t it;
        int    r;
        it.proc_id    = 8'($urandom);
        it.state_code = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            it.event_time = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else if (r < 60)
            it.event_time = 16'($urandom_range(0, 31));
        else
            it.event_time = 16'($urandom);
        if ($urandom_range(0, 99) < 3)
            it.op = OP_NONE;
        else if ($urandom_range(0, 99) < add_pct)
            it.op = ($urandom_range(0, 2) == 0) ? OP_APPEND : OP_INSERT;
        else
            it.op = OP_POP;
        return it;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(item_t it);
        in_valid   <= 1'b1;
        opcode     <= it.op;
        proc_id    <= it.proc_id;
        event_time <= it.event_time;
        state_code <= it.state_code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic idle_input(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Result side: check accepted items and vary the stall, with one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_response(result_t'({status, out_proc_id, out_state, occupancy}));
            results_seen++;
        end
        if (stretch_left > 0)
        begin
            stretch_left--;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done    = 1'b1;
            out_stall    <= 1'b1;
            stretch_left = HOLD_CYCLES;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall    <= 1'b1;
            stretch_left = pick_gap();
        end
        else
        begin
            out_stall    <= 1'b0;
            stretch_left = $urandom_range(0, 20);
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: directed items first, then random phases of filling and draining.
    initial
    begin
        item_t it;
        int    counted;
        int    add_pct;
        bit    paused;
        sb = new();
        counted = 0;
        add_pct = 50;
        paused  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pop, unused opcode, field extremes and equal times.
        send_item(make_item(OP_POP, 8'h5A, 16'h1234, 8'hA5));
        send_item(make_item(OP_NONE, 8'hFF, 16'hFFFF, 8'hFF));
        send_item(make_item(OP_APPEND, 8'hFF, 16'hFFFF, 8'hFF));
        send_item(make_item(OP_INSERT, 8'h00, 16'h0000, 8'h00));
        send_item(make_item(OP_INSERT, 8'h01, 16'd100, 8'h11));
        send_item(make_item(OP_INSERT, 8'h02, 16'd100, 8'h22));
        send_item(make_item(OP_INSERT, 8'h03, 16'hFFFF, 8'h33));
        // Fill to capacity, then try to add past it.
        for (int i = 0; i < CAPACITY - 5; i++)
            send_item(make_item(OP_INSERT, 8'(i + 16), 16'($urandom_range(0, 200)),
                                8'($urandom)));
        send_item(make_item(OP_APPEND, 8'h77, 16'h0001, 8'h77));
        send_item(make_item(OP_INSERT, 8'h88, 16'h0000, 8'h88));
        send_item(make_item(OP_NONE, 8'h00, 16'h0000, 8'h00));
        send_item(make_item(OP_POP, 8'h00, 16'h0000, 8'h00));
        send_item(make_item(OP_POP, 8'hFF, 16'hFFFF, 8'hFF));
        send_item(make_item(OP_POP, 8'h00, 16'h0000, 8'h00));

        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: add_pct = 80;
                    1: add_pct = 20;
                    default: add_pct = 50;
                endcase
            end
            // Once, let every outstanding result come back before going on.
            if (!paused && counted >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                idle_input(1);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            idle_input(pick_gap());
            it = random_item(add_pct);
            send_item(it);
            if (it.op != OP_NONE)
                counted++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
